// ===== rtl/ssfd_pkg.sv =====
// ssfd_pkg: shared types and constants for the stiff string step block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ssfd_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam int FRAC_BITS_DEF = 28;

  // register indexes
  localparam logic [2:0] REG_CENTRE      = 3'd0;
  localparam logic [2:0] REG_CENTRE_EDGE = 3'd1;
  localparam logic [2:0] REG_PREVIOUS    = 3'd2;
  localparam logic [2:0] REG_TWO_AWAY    = 3'd3;
  localparam logic [2:0] REG_ONE_AWAY    = 3'd4;
  localparam logic [2:0] REG_PREV_ADJ    = 3'd5;
  localparam logic [2:0] REG_SEG_COUNT   = 3'd6;
  localparam logic [2:0] REG_PICKUP      = 3'd7;

  localparam logic CMD_STEP   = 1'b0;
  localparam logic CMD_EXCITE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [7:0]         node_index;
    logic signed [31:0] excite_value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               saturated;
  } out_req_t;

endpackage
`default_nettype wire

// ===== rtl/stiff_string_fdtd_step.sv =====
// stiff_string_fdtd_step: stiff string finite-difference time stepper
// depends on ssfd_pkg; level memories and one shared multiplier inside
//
//  channel | dir | handshake        | payload
//  in_     | in  | in_valid/in_stall | ssfd_pkg::in_req_t
//  out_    | out | out_valid/out_stall | ssfd_pkg::out_req_t
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A step reads the eight stencil operands of each node 1..N-1 from the three
// level memories one per cycle and accumulates one product per cycle through one
// 32x32 multiplier; every other node is written zero. After reset a clearing
// pass zeroes all MAX_NODES entries of the memories; no request is taken
// meanwhile. A finished result waits in the output register while out_stall is
// high; the next request is taken in the cycle after the result leaves.
`timescale 1ns / 1ps
`default_nettype none
module stiff_string_fdtd_step #(
  parameter int MAX_NODES = ssfd_pkg::MAX_NODES_DEF,
  parameter int FRAC_BITS = ssfd_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire ssfd_pkg::in_req_t in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output ssfd_pkg::out_req_t  out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [2:0]           cfg_index,
  input  wire [31:0]          cfg_data
);
  import ssfd_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int NW = AW + 1;
  localparam int ACCW = 72;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EX_RD, S_EX_WAIT, S_EX_WR,
    S_ND_START, S_ND_RD, S_ND_MUL, S_ND_ROUND, S_ND_WR, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic signed [31:0] c_ce_r, c_cee_r, c_cp_r, c_c2_r, c_c1_r, c_cpa_r;
  logic [7:0] seg_r, pick_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ce_r <= '0; c_cee_r <= '0; c_cp_r <= '0; c_c2_r <= '0;
      c_c1_r <= '0; c_cpa_r <= '0; seg_r <= 8'd4; pick_r <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTRE:      c_ce_r  <= cfg_data;
        REG_CENTRE_EDGE: c_cee_r <= cfg_data;
        REG_PREVIOUS:    c_cp_r  <= cfg_data;
        REG_TWO_AWAY:    c_c2_r  <= cfg_data;
        REG_ONE_AWAY:    c_c1_r  <= cfg_data;
        REG_PREV_ADJ:    c_cpa_r <= cfg_data;
        REG_SEG_COUNT:   seg_r   <= cfg_data[7:0];
        REG_PICKUP:      pick_r  <= cfg_data[7:0];
        default:         ;
      endcase
    end
  end

  // clamped segment count
  logic [NW-1:0] n_eff;
  always_comb begin
    if (seg_r < 8'd4) n_eff = NW'(4);
    else if ({{(NW > 8 ? NW-8 : 0){1'b0}}, seg_r} > NW'(MAX_NODES - 1))
      n_eff = NW'(MAX_NODES - 1);
    else n_eff = NW'(seg_r);
  end

  // three level memories, one read and one write port each
  logic [31:0] mem_a [MAX_NODES];
  logic [31:0] mem_b [MAX_NODES];
  logic [31:0] mem_c [MAX_NODES];
  logic [1:0]  rd_sel, wr_sel;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [31:0] wr_val;
  logic [31:0] rd_a_r, rd_b_r, rd_c_r;
  logic [1:0]  rd_sel_r;

  always_ff @(posedge clk) begin
    rd_a_r <= mem_a[rd_addr];
    rd_b_r <= mem_b[rd_addr];
    rd_c_r <= mem_c[rd_addr];
    rd_sel_r <= rd_sel;
    if (wr_en && (wr_sel == 2'd0 || state_r == S_CLEAR)) mem_a[wr_addr] <= wr_val;
    if (wr_en && (wr_sel == 2'd1 || state_r == S_CLEAR)) mem_b[wr_addr] <= wr_val;
    if (wr_en && (wr_sel == 2'd2 || state_r == S_CLEAR)) mem_c[wr_addr] <= wr_val;
  end

  logic [31:0] rd_q;
  always_comb begin
    case (rd_sel_r)
      2'd1:    rd_q = rd_b_r;
      2'd2:    rd_q = rd_c_r;
      default: rd_q = rd_a_r;
    endcase
  end

  // sequencer registers
  logic [1:0]    phase_r;
  logic [NW-1:0] node_r;
  logic [3:0]    tap_r;
  logic          rd_ok_r;
  logic [3:0]    mtap_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [63:0] prod_r;
  logic          prod_v_r;
  logic [31:0]   new_r;
  logic          sat_r;
  in_req_t       req_r;
  out_req_t      out_r;
  logic [31:0]   pick_val_r;
  logic signed [31:0] mcoef_q, opnd_q;

  logic [1:0] cur_sel, prev_sel, next_sel;
  always_comb begin
    cur_sel  = (phase_r == 2'd3) ? 2'd0 : phase_r;
    next_sel = (cur_sel == 2'd2) ? 2'd0 : cur_sel + 2'd1;
    prev_sel = (cur_sel == 2'd0) ? 2'd2 : cur_sel - 2'd1;
  end

  // stencil tap decode: level select and node offset
  logic          tap_prev;
  logic signed [2:0] tap_off;
  always_comb begin
    tap_prev = 1'b0;
    tap_off  = 3'sd0;
    case (tap_r)
      4'd0: tap_off = 3'sd0;
      4'd1: begin tap_prev = 1'b1; tap_off = 3'sd0; end
      4'd2: tap_off = -3'sd2;
      4'd3: tap_off = 3'sd2;
      4'd4: tap_off = -3'sd1;
      4'd5: tap_off = 3'sd1;
      4'd6: begin tap_prev = 1'b1; tap_off = -3'sd1; end
      4'd7: begin tap_prev = 1'b1; tap_off = 3'sd1; end
      default: tap_off = 3'sd0;
    endcase
  end

  logic signed [NW+1:0] tap_node;
  logic                 tap_in;
  assign tap_node = $signed({2'b00, node_r}) + (NW+2)'(tap_off);
  assign tap_in   = (tap_node >= 1) && (tap_node < $signed({2'b00, n_eff}));

  // coefficient for the product being formed
  logic signed [31:0] mcoef;
  always_comb begin
    case (mtap_r)
      4'd0: mcoef = (node_r == NW'(1) || node_r == n_eff - NW'(1)) ? c_cee_r : c_ce_r;
      4'd1: mcoef = c_cp_r;
      4'd2, 4'd3: mcoef = c_c2_r;
      4'd4, 4'd5: mcoef = c_c1_r;
      default: mcoef = c_cpa_r;
    endcase
  end

  // rounding and saturation of the accumulated sum
  logic signed [ACCW-1:0] rnd;
  logic [31:0] sat_val;
  logic        sat_hit;
  always_comb begin
    rnd = (acc_r + (ACCW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    sat_hit = 1'b0;
    sat_val = rnd[31:0];
    if (rnd > ACCW'(64'sh7FFFFFFF)) begin
      sat_hit = 1'b1; sat_val = 32'h7FFFFFFF;
    end else if (rnd < -(ACCW'(64'sh80000000))) begin
      sat_hit = 1'b1; sat_val = 32'h80000000;
    end
  end

  // excite sum
  logic signed [32:0] ex_sum;
  logic [31:0]        ex_val;
  logic               ex_sat;
  always_comb begin
    ex_sum = $signed({rd_q[31], rd_q}) + $signed({req_r.excite_value[31], req_r.excite_value});
    ex_sat = (ex_sum[32] != ex_sum[31]);
    ex_val = ex_sat ? (ex_sum[32] ? 32'h80000000 : 32'h7FFFFFFF) : ex_sum[31:0];
  end

  logic ex_ok;
  assign ex_ok = (req_r.node_index != 8'd0) &&
                 ({{(NW > 8 ? NW-8 : 0){1'b0}}, req_r.node_index} < n_eff);

  // memory port drive
  always_comb begin
    rd_sel  = tap_prev ? prev_sel : cur_sel;
    rd_addr = tap_node[AW-1:0];
    wr_en   = 1'b0;
    wr_sel  = next_sel;
    wr_addr = node_r[AW-1:0];
    wr_val  = '0;
    case (state_r)
      S_CLEAR: wr_en = 1'b1;
      S_EX_RD: begin rd_sel = cur_sel; rd_addr = req_r.node_index[AW-1:0]; end
      S_EX_WAIT: begin rd_sel = cur_sel; rd_addr = req_r.node_index[AW-1:0]; end
      S_EX_WR: begin
        wr_en = ex_ok; wr_sel = cur_sel;
        wr_addr = req_r.node_index[AW-1:0]; wr_val = ex_val;
      end
      S_ND_WR: begin wr_en = 1'b1; wr_val = new_r; end
      default: ;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  logic node_live;
  assign node_live = (node_r >= NW'(1)) && (node_r < n_eff);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      phase_r <= 2'd0;
      node_r  <= '0;
      tap_r   <= '0;
      prod_v_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          node_r <= node_r + NW'(1);
          if (node_r == NW'(MAX_NODES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          req_r <= in_data;
          if (in_data.command == CMD_EXCITE) state_r <= S_EX_RD;
          else begin
            node_r <= '0; sat_r <= 1'b0; pick_val_r <= '0;
            state_r <= S_ND_START;
          end
        end
        S_EX_RD:   state_r <= S_EX_WAIT;
        S_EX_WAIT: state_r <= S_EX_WR;
        S_EX_WR: begin
          out_r.sample    <= ex_ok ? ex_val : '0;
          out_r.saturated <= ex_ok & ex_sat;
          state_r <= S_OUT;
        end
        S_ND_START: begin
          acc_r <= '0; tap_r <= '0; prod_v_r <= 1'b0;
          new_r <= '0;
          state_r <= node_live ? S_ND_RD : S_ND_WR;
        end
        S_ND_RD: begin
          // issue one read per cycle; products follow through the read register and the operand stage
          rd_ok_r <= tap_in;
          mtap_r  <= tap_r;
          tap_r   <= tap_r + 4'd1;
          if (tap_r == 4'd7) state_r <= S_ND_MUL;
          if (tap_r >= 4'd2) begin
            prod_r   <= 64'($signed(mcoef_q)) * 64'($signed(opnd_q));
          end
          if (prod_v_r) acc_r <= acc_r + ACCW'(prod_r);
          prod_v_r <= (tap_r >= 4'd2);
        end
        S_ND_MUL: begin
          // drain the last two products through the pipeline
          tap_r <= tap_r + 4'd1;
          if (tap_r <= 4'd9) prod_r <= 64'($signed(mcoef_q)) * 64'($signed(opnd_q));
          if (prod_v_r) acc_r <= acc_r + ACCW'(prod_r);
          prod_v_r <= (tap_r <= 4'd9);
          if (tap_r == 4'd10) state_r <= S_ND_ROUND;
        end
        S_ND_ROUND: begin
          new_r <= sat_val;
          if (sat_hit) sat_r <= 1'b1;
          state_r <= S_ND_WR;
        end
        S_ND_WR: begin
          if (node_live && node_r == NW'(pick_r))
            pick_val_r <= new_r;
          if (node_r == NW'(MAX_NODES - 1)) begin
            phase_r <= next_sel;
            out_r.sample    <= (node_live && node_r == NW'(pick_r)) ? new_r : pick_val_r;
            out_r.saturated <= sat_r;
            state_r <= S_OUT;
          end else begin
            node_r  <= node_r + NW'(1);
            state_r <= S_ND_START;
          end
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // operand and coefficient stage in front of the multiplier
  always_ff @(posedge clk) begin
    mcoef_q <= mcoef;
    opnd_q  <= rd_ok_r ? rd_q : 32'd0;
  end

endmodule
`default_nettype wire
